@@ src/tcot_pkg.sv @@
// ----------------------------------------------------------------------------
// tcot_pkg: shared types and codes
// Display protocol codes, sequencer states and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcot_pkg;

    localparam logic [7:0] CH_BELL  = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_CARET = 8'd94;

    localparam logic [7:0] LIFT_ESC = 8'o177;
    localparam logic [7:0] LIFT_ADD = 8'o176;
    localparam logic [7:0] CTL_BIT  = 8'o100;
    localparam logic [7:0] CTL_MAX  = 8'o037;

    localparam logic [7:0] C_MOVE4 = 8'o200;
    localparam logic [7:0] C_MOVE1 = 8'o201;
    localparam logic [7:0] C_EOF   = 8'o202;
    localparam logic [7:0] C_EOL   = 8'o203;
    localparam logic [7:0] C_DLF   = 8'o204;
    localparam logic [7:0] C_CRLF  = 8'o207;
    localparam logic [7:0] C_NOP   = 8'o210;
    localparam logic [7:0] C_BACK  = 8'o211;
    localparam logic [7:0] C_UP    = 8'o213;
    localparam logic [7:0] C_ORS   = 8'o214;
    localparam logic [7:0] C_FWD   = 8'o216;
    localparam logic [7:0] C_MOVE0 = 8'o217;
    localparam logic [7:0] C_CLEAR = 8'o220;
    localparam logic [7:0] C_BELL  = 8'o221;
    localparam logic [7:0] C_INSL  = 8'o223;
    localparam logic [7:0] C_DELL  = 8'o224;
    localparam logic [7:0] C_INSC  = 8'o225;
    localparam logic [7:0] C_DELC  = 8'o226;
    localparam logic [7:0] C_BOW   = 8'o227;
    localparam logic [7:0] C_RST   = 8'o230;

    localparam logic [4:0] MAX_OUT = 5'd24;

    localparam logic [2:0] REG_LINES   = 3'd0;
    localparam logic [2:0] REG_COLUMNS = 3'd1;
    localparam logic [2:0] REG_SCROLL  = 3'd2;
    localparam logic [2:0] REG_SCR_EN  = 3'd3;
    localparam logic [2:0] REG_ERASE   = 3'd4;
    localparam logic [2:0] REG_DIRECT  = 3'd5;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_START  = 16'h0002,
        ST_DISP   = 16'h0004,
        ST_PRINT  = 16'h0008,
        ST_APRINT = 16'h0010,
        ST_NL0    = 16'h0020,
        ST_NL1    = 16'h0040,
        ST_BOT0   = 16'h0080,
        ST_BOT1   = 16'h0100,
        ST_BOT2   = 16'h0200,
        ST_CUR0   = 16'h0400,
        ST_CUR1   = 16'h0800,
        ST_CUR2   = 16'h1000,
        ST_TABSET = 16'h2000,
        ST_TABFWD = 16'h4000,
        ST_DONE   = 16'h8000
    } state_t;

    typedef enum logic [2:0] {
        MD_NORMAL, MD_ESC, MD_MOVE4, MD_MOVE2, MD_SKIP1
    } mode_t;

    typedef enum logic [1:0] {CHOP_HOLD, CHOP_HOST, CHOP_LIFT, CHOP_LOW7} c_op_t;
    typedef enum logic [2:0] {EM_CONST, EM_CHAR, EM_LINE, EM_COL, EM_PBYTE, EM_HOST} emit_sel_t;
    typedef enum logic [2:0] {LOP_KEEP, LOP_INC, LOP_DEC, LOP_ZERO, LOP_SCROLL, LOP_ARG} line_op_t;
    typedef enum logic [2:0] {
        COP_KEEP, COP_INC, COP_DEC, COP_ZERO, COP_TAB, COP_OVER, COP_RESTORE, COP_ARG
    } col_op_t;

    typedef struct packed {
        logic      load_host;
        c_op_t     c_op;
        logic      emit;
        emit_sel_t esel;
        logic [7:0] ecode;
        line_op_t  line_op;
        col_op_t   col_op;
        logic      wrap_set;
        logic      wrap_clr;
        logic      arg_clr;
        logic      arg_store;
        logic      arg_hi;
        logic      tab_load;
        logic      p_load;
        logic      p_next;
        logic      keep_load;
        logic      fwd_dec;
        logic      flush;
    } cmd_t;

    typedef struct packed {
        logic [8:0] c;
        logic       col_nz;
        logic       line_nz;
        logic       at_bot;
        logic       wrap;
        logic       tab_ge;
        logic       inc_ge;
        logic       scroll_on;
        logic       erase;
        logic       keep_nz;
        logic       fwd_nz;
        logic       more;
        logic       ge2;
        logic       ge4;
        logic       stall;
    } status_t;

endpackage

`default_nettype wire

@@ src/tcot_dp.sv @@
// ----------------------------------------------------------------------------
// tcot_dp: translator datapath
// Configuration, cursor, argument and print registers plus the output
// holding stage that marks the last byte of each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcot_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tcot_pkg::cmd_t cmd,
    output tcot_pkg::status_t   sts,
    input  wire logic [7:0]     host_byte,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [7:0]     cfg_data,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import tcot_pkg::*;

    logic [7:0] lines_reg, cols_reg;
    logic [5:0] scroll_reg;
    logic       scr_en_reg, erase_reg, direct_reg;

    logic [7:0] hb_reg;
    logic [8:0] c_reg;
    logic [7:0] line_reg, col_reg, keep_reg, over_reg, pbyte_reg, ch_reg;
    logic       wrap_reg, more_reg;
    logic [2:0] fwd_reg;
    logic [7:0] arg_reg [4];
    logic [2:0] argcnt_reg;

    logic       pend_v_reg, out_v_reg, out_l_reg;
    logic [7:0] pend_b_reg, out_b_reg;
    logic [4:0] ocnt_reg;

    logic [7:0] bottom, tab_col, line_sub, line_scr, ebyte;
    logic [5:0] scr_d;
    logic       caret, do_emit, out_load, out_last;

    assign bottom   = lines_reg - 8'd1;
    assign tab_col  = {col_reg[7:3] + 5'd1, 3'b000};
    assign scr_d    = scroll_reg - 6'd1;
    assign line_sub = line_reg - {2'b00, scr_d};
    // upward scroll saturates at line 0
    assign line_scr = (scroll_reg > 6'd1)
                    ? ((line_reg > {2'b00, scr_d}) ? line_sub : 8'd0) : line_reg;
    assign caret    = (c_reg <= {1'b0, CTL_MAX}) && !direct_reg;

    always_comb
    begin
        unique case (cmd.esel)
            EM_CONST: ebyte = cmd.ecode;
            EM_CHAR:  ebyte = c_reg[7:0];
            EM_LINE:  ebyte = line_reg;
            EM_COL:   ebyte = col_reg;
            EM_PBYTE: ebyte = pbyte_reg;
            EM_HOST:  ebyte = hb_reg;
            default:  ebyte = cmd.ecode;
        endcase
    end

    assign do_emit  = cmd.emit && (ocnt_reg < MAX_OUT);
    assign out_load = pend_v_reg && (do_emit || cmd.flush);
    assign out_last = cmd.flush;

    always_comb
    begin
        sts.c         = c_reg;
        sts.col_nz    = col_reg != 8'd0;
        sts.line_nz   = line_reg != 8'd0;
        sts.at_bot    = line_reg == bottom;
        sts.wrap      = wrap_reg;
        sts.tab_ge    = tab_col >= cols_reg;
        sts.inc_ge    = (col_reg + 8'd1) >= cols_reg;
        sts.scroll_on = scr_en_reg && (scroll_reg != 6'd0);
        sts.erase     = erase_reg;
        sts.keep_nz   = keep_reg != 8'd0;
        sts.fwd_nz    = fwd_reg != 3'd0;
        sts.more      = more_reg;
        sts.ge2       = argcnt_reg >= 3'd2;
        sts.ge4       = argcnt_reg[2];
        sts.stall     = pend_v_reg && out_v_reg && !m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg  <= 8'd24;
            cols_reg   <= 8'd80;
            scroll_reg <= 6'd1;
            scr_en_reg <= 1'b0;
            erase_reg  <= 1'b0;
            direct_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINES:   lines_reg  <= cfg_data;
                REG_COLUMNS: cols_reg   <= cfg_data;
                REG_SCROLL:  scroll_reg <= cfg_data[5:0];
                REG_SCR_EN:  scr_en_reg <= cfg_data[0];
                REG_ERASE:   erase_reg  <= cfg_data[0];
                REG_DIRECT:  direct_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= 8'd0;
            col_reg    <= 8'd0;
            wrap_reg   <= 1'b0;
            argcnt_reg <= 3'd0;
            arg_reg[0] <= 8'd0;
            arg_reg[1] <= 8'd0;
            arg_reg[2] <= 8'd0;
            arg_reg[3] <= 8'd0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            ocnt_reg   <= 5'd0;
            more_reg   <= 1'b0;
            fwd_reg    <= 3'd0;
        end
        else
        begin
            unique case (cmd.line_op)
                LOP_KEEP:   line_reg <= line_reg;
                LOP_INC:    line_reg <= line_reg + 8'd1;
                LOP_DEC:    line_reg <= line_reg - 8'd1;
                LOP_ZERO:   line_reg <= 8'd0;
                LOP_SCROLL: line_reg <= line_scr;
                LOP_ARG:    line_reg <= cmd.arg_hi ? arg_reg[2] : arg_reg[0];
                default:    line_reg <= line_reg;
            endcase
            unique case (cmd.col_op)
                COP_KEEP:    col_reg <= col_reg;
                COP_INC:     col_reg <= col_reg + 8'd1;
                COP_DEC:     col_reg <= col_reg - 8'd1;
                COP_ZERO:    col_reg <= 8'd0;
                COP_TAB:     col_reg <= tab_col;
                COP_OVER:    col_reg <= over_reg;
                COP_RESTORE: col_reg <= keep_reg;
                COP_ARG:     col_reg <= cmd.arg_hi ? arg_reg[3] : arg_reg[1];
                default:     col_reg <= col_reg;
            endcase
            if (cmd.wrap_set)
                wrap_reg <= 1'b1;
            else if (cmd.wrap_clr)
                wrap_reg <= 1'b0;

            if (cmd.arg_clr)
                argcnt_reg <= 3'd0;
            else if (cmd.arg_store)
            begin
                arg_reg[argcnt_reg[1:0]] <= hb_reg;
                argcnt_reg <= argcnt_reg + 3'd1;
            end

            if (cmd.p_load)
                more_reg <= caret;
            else if (cmd.p_next)
                more_reg <= 1'b0;

            if (cmd.tab_load)
                fwd_reg <= ((tab_col - cols_reg) > 8'd7) ? 3'd7 : 3'((tab_col - cols_reg));
            else if (cmd.fwd_dec)
                fwd_reg <= fwd_reg - 3'd1;

            // one byte is held back so the last one of an item can be marked
            if (out_load)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;

            if (do_emit)
            begin
                pend_v_reg <= 1'b1;
                ocnt_reg   <= ocnt_reg + 5'd1;
            end
            else if (cmd.flush)
            begin
                pend_v_reg <= 1'b0;
                ocnt_reg   <= 5'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_host)
            hb_reg <= host_byte;
        unique case (cmd.c_op)
            CHOP_HOLD: c_reg <= c_reg;
            CHOP_HOST: c_reg <= {1'b0, hb_reg};
            CHOP_LIFT: c_reg <= {1'b0, hb_reg} + {1'b0, LIFT_ADD};
            CHOP_LOW7: c_reg <= {2'b00, c_reg[6:0]};
            default:   c_reg <= c_reg;
        endcase
        if (cmd.tab_load)
            over_reg <= tab_col - cols_reg;
        if (cmd.keep_load)
            keep_reg <= col_reg;
        if (cmd.p_load)
        begin
            pbyte_reg <= caret ? CH_CARET : c_reg[7:0];
            ch_reg    <= c_reg[7:0] | CTL_BIT;
        end
        else if (cmd.p_next)
            pbyte_reg <= ch_reg;
        if (do_emit)
            pend_b_reg <= ebyte;
        if (out_load)
        begin
            out_b_reg <= pend_b_reg;
            out_l_reg <= out_last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_b_reg;
    assign m_tlast  = out_l_reg;

endmodule

`default_nettype wire

@@ src/tcot_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcot_ctrl: translator sequencer
// Walks each host byte through the decode, cursor-move, newline and bottom
// line routines, at most one output byte per step, issuing datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcot_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire tcot_pkg::status_t sts,
    output tcot_pkg::cmd_t         cmd
);
    import tcot_pkg::*;

    state_t state_reg, state_next;
    state_t cur_ret_reg, cur_ret_next;
    state_t bot_ret_reg, bot_ret_next;
    state_t nl_ret_reg, nl_ret_next;
    mode_t  mode_reg, mode_next;
    cmd_t   c;

    assign s_tready = state_reg == ST_IDLE;

    always_comb
    begin
        c            = '0;
        state_next   = state_reg;
        cur_ret_next = cur_ret_reg;
        bot_ret_next = bot_ret_reg;
        nl_ret_next  = nl_ret_reg;
        mode_next    = mode_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    c.load_host = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                unique case (mode_reg)
                    MD_ESC:
                    begin
                        mode_next  = MD_NORMAL;
                        c.c_op     = CHOP_LIFT;
                        state_next = ST_DISP;
                    end
                    MD_MOVE4, MD_MOVE2:
                    begin
                        c.arg_hi = mode_reg == MD_MOVE4;
                        if ((mode_reg == MD_MOVE4) ? sts.ge4 : sts.ge2)
                        begin
                            // deferred move lands before this byte is decoded
                            c.line_op  = LOP_ARG;
                            c.col_op   = COP_ARG;
                            c.wrap_clr = 1'b1;
                            mode_next  = MD_NORMAL;
                            c.c_op     = CHOP_HOST;
                            state_next = ST_DISP;
                        end
                        else
                        begin
                            c.arg_store = 1'b1;
                            c.emit      = 1'b1;
                            c.esel      = EM_HOST;
                            state_next  = ST_DONE;
                        end
                    end
                    MD_SKIP1:
                    begin
                        mode_next  = MD_NORMAL;
                        c.emit     = 1'b1;
                        c.esel     = EM_HOST;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        mode_next  = MD_NORMAL;
                        c.c_op     = CHOP_HOST;
                        state_next = ST_DISP;
                    end
                endcase
            end
            ST_DISP:
            begin
                c.arg_clr    = 1'b1;
                state_next   = ST_DONE;
                cur_ret_next = ST_DONE;
                if (sts.c == {1'b0, LIFT_ESC})
                    mode_next = MD_ESC;
                else if (!sts.c[8] && !sts.c[7])
                begin
                    unique case (sts.c[7:0])
                        CH_BELL:
                        begin
                            c.emit  = 1'b1;
                            c.ecode = C_BELL;
                        end
                        CH_BS:
                        begin
                            if (sts.col_nz)
                            begin
                                c.col_op   = COP_DEC;
                                state_next = ST_CUR0;
                            end
                        end
                        CH_CR:
                        begin
                            if (sts.col_nz)
                            begin
                                c.col_op   = COP_ZERO;
                                state_next = ST_CUR0;
                            end
                        end
                        CH_LF:
                        begin
                            if (sts.wrap)
                            begin
                                c.col_op = COP_ZERO;
                                if (!sts.at_bot)
                                begin
                                    c.line_op = LOP_INC;
                                    c.emit    = 1'b1;
                                    c.ecode   = C_CRLF;
                                end
                                else
                                begin
                                    bot_ret_next = ST_DONE;
                                    state_next   = ST_BOT0;
                                end
                            end
                            else if (!sts.at_bot)
                            begin
                                c.line_op  = LOP_INC;
                                state_next = ST_CUR0;
                            end
                            else
                            begin
                                bot_ret_next = ST_DONE;
                                state_next   = ST_BOT0;
                            end
                        end
                        CH_TAB:
                        begin
                            c.col_op   = COP_TAB;
                            c.tab_load = 1'b1;
                            if (sts.tab_ge)
                            begin
                                nl_ret_next = ST_TABSET;
                                state_next  = ST_NL0;
                            end
                            else
                                state_next = ST_CUR0;
                        end
                        default:
                        begin
                            c.p_load   = 1'b1;
                            state_next = ST_PRINT;
                        end
                    endcase
                end
                else
                begin
                    unique case (sts.c)
                        {1'b0, C_UP}:
                        begin
                            c.wrap_clr = 1'b1;
                            if (sts.line_nz)
                            begin
                                c.line_op  = LOP_DEC;
                                state_next = ST_CUR0;
                            end
                        end
                        {1'b0, C_BACK}:
                        begin
                            if (sts.col_nz)
                            begin
                                c.col_op   = COP_DEC;
                                state_next = ST_CUR0;
                            end
                        end
                        {1'b0, C_MOVE4}:
                        begin
                            mode_next = MD_MOVE4;
                            c.emit    = 1'b1;
                            c.esel    = EM_CHAR;
                        end
                        {1'b0, C_MOVE1}, {1'b0, C_MOVE0}:
                        begin
                            mode_next = MD_MOVE2;
                            c.emit    = 1'b1;
                            c.esel    = EM_CHAR;
                        end
                        {1'b0, C_INSL}, {1'b0, C_DELL}, {1'b0, C_INSC}, {1'b0, C_DELC}:
                        begin
                            mode_next = MD_SKIP1;
                            c.emit    = 1'b1;
                            c.esel    = EM_CHAR;
                        end
                        {1'b0, C_NOP}, {1'b0, C_EOF}, {1'b0, C_EOL}, {1'b0, C_DLF},
                        {1'b0, C_ORS}, {1'b0, C_BELL}, {1'b0, C_BOW}, {1'b0, C_RST}:
                        begin
                            c.emit = 1'b1;
                            c.esel = EM_CHAR;
                        end
                        {1'b0, C_CRLF}:
                        begin
                            c.col_op = COP_ZERO;
                            if (!sts.at_bot)
                            begin
                                c.line_op = LOP_INC;
                                c.emit    = 1'b1;
                                c.ecode   = C_CRLF;
                            end
                            else
                            begin
                                bot_ret_next = ST_DONE;
                                state_next   = ST_BOT0;
                            end
                        end
                        {1'b0, C_FWD}:
                        begin
                            c.col_op = COP_INC;
                            c.emit   = 1'b1;
                            c.esel   = EM_CHAR;
                        end
                        {1'b0, C_CLEAR}:
                        begin
                            c.wrap_clr = 1'b1;
                            c.col_op   = COP_ZERO;
                            c.line_op  = LOP_ZERO;
                            c.emit     = 1'b1;
                            c.esel     = EM_CHAR;
                        end
                        default:
                        begin
                            // meaningless code: strip to seven bits and decode again
                            c.c_op     = CHOP_LOW7;
                            state_next = ST_DISP;
                        end
                    endcase
                end
            end
            ST_PRINT:
            begin
                c.emit   = 1'b1;
                c.esel   = EM_PBYTE;
                c.col_op = COP_INC;
                if (sts.inc_ge)
                begin
                    nl_ret_next = ST_APRINT;
                    state_next  = ST_NL0;
                end
                else
                    state_next = ST_APRINT;
            end
            ST_APRINT:
            begin
                if (sts.more)
                begin
                    c.p_next   = 1'b1;
                    state_next = ST_PRINT;
                end
                else
                    state_next = ST_DONE;
            end
            ST_NL0:
            begin
                if (sts.col_nz)
                begin
                    c.col_op     = COP_ZERO;
                    cur_ret_next = ST_NL1;
                    state_next   = ST_CUR0;
                end
                else
                    state_next = ST_NL1;
            end
            ST_NL1:
            begin
                if (sts.wrap)
                begin
                    c.col_op = COP_ZERO;
                    if (!sts.at_bot)
                    begin
                        c.line_op  = LOP_INC;
                        c.emit     = 1'b1;
                        c.ecode    = C_CRLF;
                        state_next = nl_ret_reg;
                    end
                    else
                    begin
                        bot_ret_next = nl_ret_reg;
                        state_next   = ST_BOT0;
                    end
                end
                else if (!sts.at_bot)
                begin
                    c.line_op    = LOP_INC;
                    cur_ret_next = nl_ret_reg;
                    state_next   = ST_CUR0;
                end
                else
                begin
                    bot_ret_next = nl_ret_reg;
                    state_next   = ST_BOT0;
                end
            end
            ST_BOT0:
            begin
                if (sts.scroll_on)
                begin
                    c.line_op  = LOP_SCROLL;
                    c.emit     = 1'b1;
                    c.ecode    = C_CRLF;
                    state_next = ST_BOT1;
                end
                else
                begin
                    c.keep_load  = 1'b1;
                    c.wrap_set   = 1'b1;
                    c.line_op    = LOP_ZERO;
                    c.col_op     = COP_ZERO;
                    cur_ret_next = ST_BOT2;
                    state_next   = ST_CUR0;
                end
            end
            ST_BOT1:
            begin
                if (sts.col_nz)
                begin
                    cur_ret_next = bot_ret_reg;
                    state_next   = ST_CUR0;
                end
                else
                    state_next = bot_ret_reg;
            end
            ST_BOT2:
            begin
                c.emit  = sts.erase;
                c.ecode = C_EOL;
                if (sts.keep_nz)
                begin
                    c.col_op     = COP_RESTORE;
                    cur_ret_next = bot_ret_reg;
                    state_next   = ST_CUR0;
                end
                else
                    state_next = bot_ret_reg;
            end
            ST_CUR0:
            begin
                c.emit     = 1'b1;
                c.ecode    = C_MOVE0;
                state_next = ST_CUR1;
            end
            ST_CUR1:
            begin
                c.emit     = 1'b1;
                c.esel     = EM_LINE;
                state_next = ST_CUR2;
            end
            ST_CUR2:
            begin
                c.emit     = 1'b1;
                c.esel     = EM_COL;
                state_next = cur_ret_reg;
            end
            ST_TABSET:
            begin
                c.col_op   = COP_OVER;
                state_next = ST_TABFWD;
            end
            ST_TABFWD:
            begin
                if (sts.fwd_nz)
                begin
                    c.emit    = 1'b1;
                    c.ecode   = C_FWD;
                    c.fwd_dec = 1'b1;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                c.flush    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase

        // output stage full: freeze this step
        if (state_reg != ST_IDLE && sts.stall)
        begin
            c            = '0;
            state_next   = state_reg;
            cur_ret_next = cur_ret_reg;
            bot_ret_next = bot_ret_reg;
            nl_ret_next  = nl_ret_reg;
            mode_next    = mode_reg;
        end
    end

    assign cmd = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_ret_reg <= ST_DONE;
            bot_ret_reg <= ST_DONE;
            nl_ret_reg  <= ST_DONE;
            mode_reg    <= MD_NORMAL;
        end
        else
        begin
            state_reg   <= state_next;
            cur_ret_reg <= cur_ret_next;
            bot_ret_reg <= bot_ret_next;
            nl_ret_reg  <= nl_ret_next;
            mode_reg    <= mode_next;
        end
    end

endmodule

`default_nettype wire

@@ src/terminal_cursor_output_translator_top.sv @@
// ----------------------------------------------------------------------------
// terminal_cursor_output_translator_top: host byte to display protocol
// Translates host output bytes into display protocol bytes, tracking the
// cursor line and column.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one host byte per item (s_tdata[7:0]). m_* returns 0 to 24
//   protocol bytes per item (m_tdata[7:0]); m_tlast marks the last byte an
//   item caused. Items that cause no byte produce nothing on m_*.
//   cfg_we/cfg_index/cfg_data write the six setup registers; write them only
//   while the block is idle.
//   One item is worked at a time: s_tready is high only in the idle state, so
//   a new item is taken only once the sequencer has finished all steps the
//   last one needed (start, decode, each cursor-move byte, newline and bottom
//   checks, done), and output stalls hold those steps.
//   The first byte passes the pending and output registers before it shows on
//   m_*; one byte is held back so that the last one can carry m_tlast.
//   Reset restores the default setup (24 lines, 80 columns, scroll 1) and
//   clears the cursor and parse state.
//   When m_tready is low with the output stage full, the sequencer freezes
//   and s_tready stays low until the item is finished.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module terminal_cursor_output_translator_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] host_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] link_byte
    output logic            m_tlast,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import tcot_pkg::*;

    cmd_t    cmd;
    status_t sts;

    tcot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcot_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .host_byte (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ src/tcot_chk.sv @@
// ----------------------------------------------------------------------------
// tcot_chk: port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcot_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("output appeared in the cycle after acceptance");

endmodule

bind terminal_cursor_output_translator_top tcot_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/terminal_cursor_output_translator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_cursor_output_translator_top_tb: self-checking bench
// Streams host bytes into the translator under several screen setups. A
// cursor-tracking model predicts every link byte and its tlast flag. Each
// byte that leaves the block is checked in order against that prediction.
// Both stream sides idle at random. One long output stall backs the block
// up, and input pauses let the output drain.
// ----------------------------------------------------------------------------

module terminal_cursor_output_translator_top_tb;

    import tcot_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } link_item_t;

    class link_byte_predictor;
        logic [7:0] lines, columns;
        logic [5:0] scroll;
        logic       scroll_en, erase, direct;
        mode_t      mode;
        int unsigned nargs;
        logic [7:0] args [4];
        logic       wrap;
        logic [7:0] line, col;
        logic [7:0] pending [$];
        link_item_t expected_link [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            lines = 24; columns = 80; scroll = 1;
            scroll_en = 0; erase = 0; direct = 0;
            mode = MD_NORMAL; nargs = 0;
            foreach (args[i]) args[i] = 0;
            wrap = 0; line = 0; col = 0;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] v);
            case (idx)
                REG_LINES:   lines = v;
                REG_COLUMNS: columns = v;
                REG_SCROLL:  scroll = v[5:0];
                REG_SCR_EN:  scroll_en = v[0];
                REG_ERASE:   erase = v[0];
                REG_DIRECT:  direct = v[0];
                default: ;
            endcase
        endfunction

        function void put(int unsigned v);
            if (pending.size() < MAX_OUT) pending.push_back(v[7:0]);
        endfunction

        function void put_cursor();
            put(C_MOVE0);
            put(line);
            put(col);
        endfunction

        function void bottom_reached();
            logic [7:0] keep;
            if (scroll_en && scroll != 0) begin
                if (scroll > 1)
                    line = (line > scroll - 1) ? line - (scroll - 1) : 8'd0;
                put(C_CRLF);
                if (col != 0) put_cursor();
            end
            else begin
                keep = col;
                wrap = 1;
                line = 0;
                col = 0;
                put_cursor();
                if (erase) put(C_EOL);
                if (keep != 0) begin
                    col = keep;
                    put_cursor();
                end
            end
        endfunction

        function void translate(int unsigned c_in);
            int unsigned c;
            logic [7:0] over;
            int unsigned n;
            c = c_in;
            forever
            begin
                nargs = 0;
                if (c == LIFT_ESC) begin
                    mode = MD_ESC;
                    return;
                end
                if (c < 'o200) begin
                    case (c)
                        CH_BELL: begin put(C_BELL); return; end
                        CH_BS, CH_CR:
                        begin
                            if (col != 0) begin
                                col = (c == CH_BS) ? col - 1 : 8'd0;
                                put_cursor();
                            end
                            return;
                        end
                        CH_LF:
                        begin
                            if (wrap) begin
                                c = C_CRLF;
                            end
                            else begin
                                if (line != lines - 8'd1) begin
                                    line = line + 1;
                                    put_cursor();
                                end
                                else bottom_reached();
                                return;
                            end
                        end
                        CH_TAB:
                        begin
                            do col = col + 1; while (col[2:0] != 0);
                            if (col >= columns) begin
                                over = col - columns;
                                n = over > 7 ? 7 : over;
                                translate(CH_CR);
                                translate(CH_LF);
                                col = over;
                                repeat (n) put(C_FWD);
                            end
                            else put_cursor();
                            return;
                        end
                        default:
                        begin
                            if (c <= CTL_MAX && !direct) begin
                                translate(CH_CARET);
                                c = c | CTL_BIT;
                            end
                            put(c);
                            col = col + 1;
                            if (col >= columns) begin
                                translate(CH_CR);
                                translate(CH_LF);
                            end
                            return;
                        end
                    endcase
                end
                else begin
                    case (c)
                        C_UP:
                        begin
                            if (line != 0) begin
                                line = line - 1;
                                put_cursor();
                            end
                            wrap = 0;
                            return;
                        end
                        C_BACK:
                        begin
                            if (col != 0) begin
                                col = col - 1;
                                put_cursor();
                            end
                            return;
                        end
                        C_MOVE4: begin mode = MD_MOVE4; put(c); return; end
                        C_MOVE1, C_MOVE0: begin mode = MD_MOVE2; put(c); return; end
                        C_INSL, C_DELL, C_INSC, C_DELC:
                        begin
                            mode = MD_SKIP1;
                            put(c);
                            return;
                        end
                        C_NOP, C_EOF, C_EOL, C_DLF, C_ORS, C_BELL, C_BOW, C_RST:
                        begin
                            put(c);
                            return;
                        end
                        C_CRLF:
                        begin
                            col = 0;
                            if (line != lines - 8'd1) begin
                                line = line + 1;
                                put(C_CRLF);
                            end
                            else bottom_reached();
                            return;
                        end
                        C_FWD: begin col = col + 1; put(c); return; end
                        C_CLEAR:
                        begin
                            wrap = 0; col = 0; line = 0;
                            put(c);
                            return;
                        end
                        default: c = c & 'o177;
                    endcase
                end
            end
        endfunction

        // host item accepted: predict its link bytes
        function void note_host(logic [7:0] b);
            int unsigned need;
            link_item_t e;
            pending.delete();
            case (mode)
                MD_ESC:
                begin
                    mode = MD_NORMAL;
                    translate({1'b0, b} + {1'b0, LIFT_ADD});
                end
                MD_MOVE4, MD_MOVE2:
                begin
                    need = (mode == MD_MOVE4) ? 4 : 2;
                    if (nargs >= need) begin
                        line = args[need - 2];
                        col = args[need - 1];
                        mode = MD_NORMAL;
                        wrap = 0;
                        translate(b);
                    end
                    else begin
                        args[nargs & 3] = b;
                        nargs = (nargs + 1) & 7;
                        put(b);
                    end
                end
                MD_SKIP1:
                begin
                    mode = MD_NORMAL;
                    put(b);
                end
                default:
                begin
                    mode = MD_NORMAL;
                    translate(b);
                end
            endcase
            foreach (pending[i]) begin
                e.data = pending[i];
                e.last = (i == pending.size() - 1);
                expected_link.push_back(e);
            end
        endfunction

        function void check_link(logic [7:0] data, logic last);
            link_item_t e;
            checked++;
            if (expected_link.size() == 0) begin
                errors++;
                $display("%0t: unexpected link byte: expected none, actual %h last %b",
                         $time, data, last);
                return;
            end
            e = expected_link.pop_front();
            if (data !== e.data) begin
                errors++;
                $display("%0t: link byte mismatch: expected %h, actual %h",
                         $time, e.data, data);
            end
            if (last !== e.last) begin
                errors++;
                $display("%0t: tlast mismatch on %h: expected %b, actual %b",
                         $time, e.data, e.last, last);
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       s_tvalid = 0;
    logic       s_tready;
    logic [7:0] s_tdata = 0;
    logic       m_tvalid;
    logic       m_tready = 0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_we = 0;
    logic [2:0] cfg_index = REG_LINES;
    logic [7:0] cfg_data = 0;

    link_byte_predictor cursor_model = new();
    int unsigned cycles = 0;
    int unsigned host_items = 0;
    bit no_idle = 0;
    bit hold_req = 0;

    terminal_cursor_output_translator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("terminal_cursor_output_translator_top_tb: done, errors");
            $finish;
        end
    end

    // link side: random stalls, one long hold when asked
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 0;
                repeat (300) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            cursor_model.check_link(m_tdata, m_tlast);
        end
    end

    task automatic send_host(logic [7:0] b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        cursor_model.note_host(b);
        host_items++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge clk);
        while (cursor_model.expected_link.size() != 0) @(posedge clk);
        // an item with no output may still be in the sequencer
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        cursor_model.set_reg(idx, v);
    endtask

    task automatic setup(logic [7:0] l, logic [7:0] c, logic [5:0] s,
                         logic se, logic er, logic di);
        wait_drained();
        write_reg(REG_LINES, l);
        write_reg(REG_COLUMNS, c);
        write_reg(REG_SCROLL, {2'b00, s});
        write_reg(REG_SCR_EN, {7'd0, se});
        write_reg(REG_ERASE, {7'd0, er});
        write_reg(REG_DIRECT, {7'd0, di});
    endtask

    // one random item or a short well-formed sequence
    task automatic send_random();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) send_host(8'($urandom_range(32, 126)));
        else if (pick < 52) begin
            case ($urandom_range(0, 4))
                0: send_host(CH_BELL);
                1: send_host(CH_BS);
                2: send_host(CH_TAB);
                3: send_host(CH_LF);
                default: send_host(CH_CR);
            endcase
        end
        else if (pick < 60) send_host(8'($urandom_range(0, 31)));
        else if (pick < 70) send_host(8'($urandom_range('o200, 'o230)));
        else if (pick < 76) begin
            send_host(LIFT_ESC);
            send_host(8'($urandom_range(0, 255)));
        end
        else if (pick < 84) begin
            send_host(C_MOVE0);
            send_host(8'($urandom_range(0, cursor_model.lines)));
            send_host(8'($urandom_range(0, cursor_model.columns)));
        end
        else if (pick < 88) begin
            send_host(C_MOVE4);
            repeat (4) send_host(8'($urandom_range(0, 255)));
        end
        else send_host(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [7:0] directed [$];
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // default setup: a directed mix of code paths
        directed = '{8'h41, CH_BELL, CH_BS, CH_TAB, CH_CR, CH_LF, 8'h00, 8'h1F,
                     LIFT_ESC, 8'h41, C_MOVE0, 8'd23, 8'd79, 8'h78,
                     C_MOVE4, 8'd1, 8'd2, 8'd3, 8'd4, C_INSL, LIFT_ESC,
                     C_UP, C_CLEAR, C_FWD, C_CRLF, 8'hFF};
        foreach (directed[i]) send_host(directed[i]);
        repeat (25) send_random();

        // smallest screen, scrolling off, erase and direct controls on
        setup(8'd1, 8'd1, 6'd0, 1'b1, 1'b1, 1'b1);
        repeat (20) send_random();

        // 128x240 screen, scroll 63: output held off long enough to back up
        setup(8'd128, 8'd240, 6'd63, 1'b1, 1'b0, 1'b0);
        hold_req = 1;
        no_idle = 1;
        repeat (20) send_random();
        no_idle = 0;

        // small wrapping screen; pause mid-phase until the output drains
        setup(8'd3, 8'd17, 6'd2, 1'b0, 1'b1, 1'b0);
        repeat (12) send_random();
        wait_drained();
        repeat (12) send_random();

        setup(8'd2, 8'd9, 6'd1, 1'b1, 1'b0, 1'b1);
        repeat (10) send_random();

        wait_drained();
        $display("translator run: %0d host items, %0d link bytes checked",
                 host_items, cursor_model.checked);
        $display("  setups: default, 1x1 direct, 128x240 scroll 63, wrap and scroll 1");
        if (cursor_model.errors == 0)
            $display("terminal_cursor_output_translator_top_tb: done, clean");
        else
            $display("terminal_cursor_output_translator_top_tb: done, errors");
        $finish;
    end

endmodule
